### src/jsud_pkg.sv
package jsud_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ESC   = 2'd1;
    localparam logic [1:0] ST_CUT_SHORT = 2'd2;
    localparam logic [1:0] ST_BAD_HEX   = 2'd3;

    localparam logic [15:0] CAP_RESET = 16'd256;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  hex_seen;
        logic [15:0] code_point;
        logic [15:0] out_count;
        logic        zero_seen;
        logic [15:0] len_before_zero;
        logic [1:0]  err;
        logic        halted;
    } t_dec_state;

    localparam t_dec_state DEC_STATE_CLEAR = '{
        mode: MODE_NORMAL, hex_seen: 2'd0, code_point: 16'd0, out_count: 16'd0,
        zero_seen: 1'b0, len_before_zero: 16'd0, err: ST_OK, halted: 1'b0
    };

    // Results caused by one accepted byte.
    typedef struct packed {
        logic [1:0]  nres;
        logic        bytes_valid;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic        last;
        logic [1:0]  status;
        logic [15:0] length;
    } t_batch;

endpackage

### src/jsud_step.sv
module jsud_step
    import jsud_pkg::*;
(
    input  t_dec_state  i_st,
    input  logic [15:0] i_cap,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_dec_state  o_st,
    output t_batch      o_batch
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    t_dec_state  ns;
    logic [1:0]  cand;
    logic [7:0]  c0, c1, c2;
    logic [4:0]  hv;
    logic [15:0] cp_new;
    logic [15:0] limit;
    logic [15:0] room;
    logic [1:0]  k;

    always_comb begin
        ns     = i_st;
        cand   = 2'd0;
        c0     = 8'd0;
        c1     = 8'd0;
        c2     = 8'd0;
        hv     = hex_val(i_byte);
        cp_new = {i_st.code_point[11:0], hv[3:0]};
        limit  = i_cap - 16'd1;
        room   = (i_st.out_count < limit) ? (limit - i_st.out_count) : 16'd0;

        if (!i_st.halted) begin
            unique case (i_st.mode)
                MODE_ESCAPE: begin
                    ns.mode = MODE_NORMAL;
                    cand    = 2'd1;
                    unique case (i_byte)
                        CH_QUOTE: c0 = CH_QUOTE;
                        CH_BSL:   c0 = CH_BSL;
                        CH_SLASH: c0 = CH_SLASH;
                        CH_B:     c0 = 8'h08;
                        CH_F:     c0 = 8'h0c;
                        CH_N:     c0 = 8'h0a;
                        CH_R:     c0 = 8'h0d;
                        CH_T:     c0 = 8'h09;
                        CH_U: begin
                            cand          = 2'd0;
                            ns.mode       = MODE_HEX;
                            ns.hex_seen   = 2'd0;
                            ns.code_point = 16'd0;
                        end
                        default: begin
                            cand      = 2'd0;
                            ns.err    = ST_BAD_ESC;
                            ns.halted = 1'b1;
                            ns.hex_seen = 2'd0;
                        end
                    endcase
                end
                MODE_HEX: begin
                    if (!hv[4]) begin
                        ns.err      = ST_BAD_HEX;
                        ns.halted   = 1'b1;
                        ns.mode     = MODE_NORMAL;
                        ns.hex_seen = 2'd0;
                    end else begin
                        ns.code_point = cp_new;
                        if (i_st.hex_seen == 2'd3) begin
                            ns.mode     = MODE_NORMAL;
                            ns.hex_seen = 2'd0;
                            if (cp_new < 16'h0080) begin
                                cand = 2'd1;
                                c0   = {1'b0, cp_new[6:0]};
                            end else if (cp_new < 16'h0800) begin
                                cand = 2'd2;
                                c0   = {3'b110, cp_new[10:6]};
                                c1   = {2'b10, cp_new[5:0]};
                            end else begin
                                cand = 2'd3;
                                c0   = {4'b1110, cp_new[15:12]};
                                c1   = {2'b10, cp_new[11:6]};
                                c2   = {2'b10, cp_new[5:0]};
                            end
                        end else begin
                            ns.hex_seen = i_st.hex_seen + 2'd1;
                        end
                    end
                end
                default: begin
                    ns.mode = MODE_NORMAL;
                    if (i_st.out_count < limit) begin
                        if (i_byte == CH_BSL) begin
                            ns.mode = MODE_ESCAPE;
                        end else begin
                            cand = 2'd1;
                            c0   = i_byte;
                        end
                    end
                end
            endcase

            if (i_last && !ns.halted && ns.mode != MODE_NORMAL) begin
                ns.err      = ST_CUT_SHORT;
                ns.halted   = 1'b1;
                ns.mode     = MODE_NORMAL;
                ns.hex_seen = 2'd0;
            end
        end

        // Only the first byte of a transfer can be zero.
        k            = (room < {14'd0, cand}) ? room[1:0] : cand;
        ns.out_count = i_st.out_count + {14'd0, k};
        if (k != 2'd0 && c0 == 8'd0 && !i_st.zero_seen) begin
            ns.zero_seen       = 1'b1;
            ns.len_before_zero = i_st.out_count;
        end

        o_batch.nres        = (i_last && k == 2'd0) ? 2'd1 : k;
        o_batch.bytes_valid = (k != 2'd0);
        o_batch.b0          = c0;
        o_batch.b1          = c1;
        o_batch.b2          = c2;
        o_batch.last        = i_last;
        o_batch.status      = ns.err;
        o_batch.length      = ns.zero_seen ? ns.len_before_zero : ns.out_count;

        o_st = i_last ? DEC_STATE_CLEAR : ns;
    end

endmodule

### src/json_string_unescape_decoder_unit.sv
// JSON string unescaper: raw string body bytes in, decoded bytes out.
// Input channel i_valid/o_ready carries one raw byte (i_in_byte) and the
// end-of-string mark (i_in_last) per transfer. Output channel o_valid/i_ready
// carries one result per transfer: a decoded byte with o_byte_valid, or on an
// end-of-string byte that decodes to nothing, a single result with
// o_byte_valid low. o_run_last marks the last result of an input byte,
// o_string_end the last result of the string, which also carries o_status
// and o_out_length.
// A byte's first result is registered and appears in the cycle after its
// transfer. Throughput: one input byte per cycle while the receiver is ready
// and each byte yields at most one result; a \uXXXX escape ending in 2 or 3
// UTF-8 bytes holds the result register and input until its last byte leaves.
// A stalled receiver holds the result register; input is taken again in the
// cycle the last pending result leaves. Reset clears decoder state, empties
// the result register and sets the output capacity to 256. i_cfg_we writes
// the capacity; the user must use it only when idle; it is not enforced.
module json_string_unescape_decoder_unit
    import jsud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_last,
    output logic        o_string_end,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_length
);

    logic [15:0] r_cap;
    t_dec_state  r_st;
    t_dec_state  n_st;
    t_batch      n_batch;

    logic [1:0]  r_cnt;
    logic [1:0]  r_pos;
    logic [7:0]  r_bytes [3];
    logic        r_bv;
    logic        r_last;
    logic [1:0]  r_status;
    logic [15:0] r_len;

    logic in_xfer;
    logic out_xfer;
    logic at_end;
    logic fin_last;

    jsud_step u_step (
        .i_st    (r_st),
        .i_cap   (r_cap),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .o_st    (n_st),
        .o_batch (n_batch)
    );

    assign at_end   = (r_pos == r_cnt - 2'd1);
    assign out_xfer = o_valid && i_ready;
    assign o_ready  = (r_cnt == 2'd0) || (out_xfer && at_end);
    assign in_xfer  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_st  <= DEC_STATE_CLEAR;
            r_cnt <= 2'd0;
            r_pos <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (in_xfer) begin
                r_st  <= n_st;
                r_cnt <= n_batch.nres;
                r_pos <= 2'd0;
            end else if (out_xfer) begin
                if (at_end) begin
                    r_cnt <= 2'd0;
                end
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bytes[0] <= n_batch.b0;
            r_bytes[1] <= n_batch.b1;
            r_bytes[2] <= n_batch.b2;
            r_bv       <= n_batch.bytes_valid;
            r_last     <= n_batch.last;
            r_status   <= n_batch.status;
            r_len      <= n_batch.length;
        end
    end

    assign fin_last     = at_end && r_last;
    assign o_valid      = (r_cnt != 2'd0);
    assign o_out_byte   = r_bv ? r_bytes[r_pos] : 8'd0;
    assign o_byte_valid = r_bv;
    assign o_run_last   = at_end;
    assign o_string_end = fin_last;
    assign o_status     = fin_last ? r_status : ST_OK;
    assign o_out_length = fin_last ? r_len : 16'd0;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pos < r_cnt))
        else $error("result index beyond pending count");

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_end) |-> o_run_last)
        else $error("string end not on last result of its byte");

    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_string_end && r_cnt == 2'd1))
        else $error("byteless result outside end of string");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_last) |=> (r_st == DEC_STATE_CLEAR))
        else $error("decoder state not cleared after string end");

endmodule
